// ===== hdl/rtc_pkg.sv =====
// Shared constants, beat types and helpers for the RGB tone curve core.
package rtc_pkg;

    localparam int TABLE_SIZE = 1024;
    localparam int NUM_LANES  = 3;
    localparam int CH_W       = 17;
    localparam int FRAC_W     = 16;
    localparam int IDX_W      = 10;
    localparam int AW         = $clog2(TABLE_SIZE);
    localparam int POS_W      = CH_W + AW;
    localparam int DIFF_W     = CH_W + 1;
    localparam int PROD_W     = DIFF_W + FRAC_W + 1;

    typedef logic [CH_W-1:0] chan_t;
    typedef logic [AW-1:0]   addr_t;
    typedef logic [NUM_LANES-1:0][CH_W-1:0] lane_res_t;

    localparam chan_t ONE_Q16    = CH_W'(65536);
    localparam addr_t LAST_ENTRY = AW'(TABLE_SIZE - 1);

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    localparam logic [1:0] SEL_RED   = 2'd0;
    localparam logic [1:0] SEL_GREEN = 2'd1;
    localparam logic [1:0] SEL_BLUE  = 2'd2;

    localparam logic [1:0] LANE_SEL [NUM_LANES] = '{SEL_RED, SEL_GREEN, SEL_BLUE};

    typedef struct packed {
        logic             func;
        logic [1:0]       table_select;
        logic [IDX_W-1:0] table_index;
        chan_t            table_value;
        chan_t            red_in;
        chan_t            green_in;
        chan_t            blue_in;
        chan_t            alpha_in;
    } in_beat_t;

    typedef struct packed {
        chan_t red_out;
        chan_t green_out;
        chan_t blue_out;
        chan_t alpha_out;
    } out_beat_t;

    typedef struct packed {
        logic load;
        logic read;
        logic mult;
        logic wr_en;
    } lane_ctl_t;

    function automatic chan_t sat_one(input chan_t x);
        return (x > ONE_Q16) ? ONE_Q16 : x;
    endfunction

endpackage

// ===== hdl/rtc_lane.sv =====
// One colour lane: index scaling, table memory with two read ports, interpolation.
module rtc_lane (
    input  logic              aclk,
    input  rtc_pkg::lane_ctl_t ctl,
    input  rtc_pkg::chan_t    chan_in,
    input  rtc_pkg::addr_t    wr_addr,
    input  rtc_pkg::chan_t    wr_data,
    output rtc_pkg::chan_t    result
);

    rtc_pkg::chan_t table_mem [rtc_pkg::TABLE_SIZE];

    logic [rtc_pkg::POS_W-1:0]  pos_reg;
    logic [rtc_pkg::POS_W-1:0]  pos_next;
    rtc_pkg::addr_t             lo_addr;
    rtc_pkg::addr_t             hi_addr;
    rtc_pkg::chan_t             lo_q_reg;
    rtc_pkg::chan_t             hi_q_reg;
    logic [rtc_pkg::FRAC_W-1:0] frac_reg;
    logic signed [rtc_pkg::DIFF_W-1:0] diff_next;
    logic signed [rtc_pkg::FRAC_W:0]   frac_s;
    logic signed [rtc_pkg::PROD_W-1:0] prod_next;
    logic signed [rtc_pkg::PROD_W-1:0] prod_reg;
    rtc_pkg::chan_t             base_reg;
    logic signed [rtc_pkg::PROD_W-1:0] sum;

    assign pos_next = rtc_pkg::POS_W'(rtc_pkg::sat_one(chan_in))
                    * rtc_pkg::POS_W'(rtc_pkg::TABLE_SIZE - 1);

    assign lo_addr = rtc_pkg::AW'(pos_reg >> rtc_pkg::FRAC_W);
    assign hi_addr = (lo_addr == rtc_pkg::LAST_ENTRY) ? rtc_pkg::LAST_ENTRY
                                                       : lo_addr + rtc_pkg::AW'(1);

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            table_mem[wr_addr] <= wr_data;
        end
        if (ctl.read) begin
            lo_q_reg <= table_mem[lo_addr];
            hi_q_reg <= table_mem[hi_addr];
            frac_reg <= pos_reg[rtc_pkg::FRAC_W-1:0];
        end
    end

    always_comb begin
        diff_next = $signed({1'b0, hi_q_reg}) - $signed({1'b0, lo_q_reg});
        frac_s    = $signed({1'b0, frac_reg});
        prod_next = diff_next * frac_s;
    end

    always_ff @(posedge aclk) begin
        if (ctl.mult) begin
            prod_reg <= prod_next;
            base_reg <= lo_q_reg;
        end
    end

    assign sum    = $signed(rtc_pkg::PROD_W'(base_reg)) + (prod_reg >>> rtc_pkg::FRAC_W);
    assign result = sum[rtc_pkg::CH_W-1:0];

endmodule

// ===== hdl/rtc_merge.sv =====
// Merge stage: combines lane results with alpha and bypass into a skid-buffered output.
module rtc_merge (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  logic               bypass,
    input  rtc_pkg::lane_res_t lane_res,
    input  rtc_pkg::out_beat_t raw,
    output logic               in_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output rtc_pkg::out_beat_t m_data
);

    rtc_pkg::out_beat_t beat;
    rtc_pkg::out_beat_t out_reg;
    rtc_pkg::out_beat_t out_next;
    rtc_pkg::out_beat_t skid_reg;
    rtc_pkg::out_beat_t skid_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               skid_valid_reg;
    logic               skid_valid_next;

    always_comb begin
        if (bypass) begin
            beat = raw;
        end else begin
            beat.red_out   = lane_res[0];
            beat.green_out = lane_res[1];
            beat.blue_out  = lane_res[2];
            beat.alpha_out = raw.alpha_out;
        end
    end

    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_next       = beat;
                out_valid_next = push;
            end
        end else if (push) begin
            skid_next       = beat;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign in_ready = !skid_valid_reg;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

endmodule

// ===== hdl/rgb_tone_curve_table_apply_core.sv =====
// Top level of the RGB tone curve core: input stage, three lanes, merge stage.
//
//  channel  | ports                       | beat
//  ---------+-----------------------------+---------------------------------------
//  input    | s_valid s_ready s_data      | table write (func 0) or RGBA pixel
//  output   | m_valid m_ready m_data      | RGBA pixel (mapped, or raw in bypass), one per pixel beat
//  config   | cfg_wr_en cfg_wr_data       | bypass bit, registered on cfg_wr_en
//
// One beat per cycle sustained while the output is not stalled; a pixel's path from the
// edge that takes it: index multiply at that edge, then registered two-port table read,
// interpolation multiply, output register. Table writes land at the table-read stage
// and give no result.
// Reset clears stage valid bits and sets bypass; table contents are not cleared.
// A stalled output parks one beat in the skid register; s_ready drops only when
// both output registers hold beats.
module rgb_tone_curve_table_apply_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  rtc_pkg::in_beat_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rtc_pkg::out_beat_t m_data
);

    logic bypass_reg;
    logic v1_reg;
    logic v1_next;
    logic v2_reg;
    logic v2_next;
    logic v3_reg;
    logic v3_next;

    logic                  wr_ok_reg;
    logic                  pix1_reg;
    logic [1:0]            sel1_reg;
    rtc_pkg::addr_t        addr1_reg;
    rtc_pkg::chan_t        val1_reg;
    rtc_pkg::out_beat_t    raw1_reg;
    rtc_pkg::out_beat_t    raw2_reg;
    rtc_pkg::out_beat_t    raw3_reg;

    logic accept;
    logic adv1;
    logic adv2;
    logic adv3;
    logic rdy2;
    logic rdy3;
    logic merge_ready;

    rtc_pkg::chan_t     chan_in [rtc_pkg::NUM_LANES];
    rtc_pkg::lane_ctl_t lane_ctl [rtc_pkg::NUM_LANES];
    rtc_pkg::lane_res_t lane_res;

    assign rdy3    = !v3_reg || merge_ready;
    assign adv3    = v3_reg && merge_ready;
    assign rdy2    = !v2_reg || rdy3;
    assign adv2    = v2_reg && rdy3;
    assign adv1    = v1_reg && rdy2;
    assign s_ready = !v1_reg || rdy2;
    assign accept  = s_valid && s_ready;

    always_comb begin
        v1_next = v1_reg;
        v2_next = v2_reg;
        v3_next = v3_reg;
        if (accept) begin
            v1_next = 1'b1;
        end else if (adv1) begin
            v1_next = 1'b0;
        end
        if (adv1) begin
            v2_next = pix1_reg;
        end else if (adv2) begin
            v2_next = 1'b0;
        end
        if (adv2) begin
            v3_next = 1'b1;
        end else if (adv3) begin
            v3_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bypass_reg <= 1'b1;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                bypass_reg <= cfg_wr_data;
            end
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pix1_reg  <= (s_data.func == rtc_pkg::FUNC_PIXEL);
            wr_ok_reg <= (s_data.func == rtc_pkg::FUNC_WRITE)
                      && (s_data.table_select <= rtc_pkg::SEL_BLUE)
                      && (32'(s_data.table_index) < rtc_pkg::TABLE_SIZE);
            sel1_reg  <= s_data.table_select;
            addr1_reg <= rtc_pkg::AW'(s_data.table_index);
            val1_reg  <= rtc_pkg::sat_one(s_data.table_value);
            raw1_reg.red_out   <= s_data.red_in;
            raw1_reg.green_out <= s_data.green_in;
            raw1_reg.blue_out  <= s_data.blue_in;
            raw1_reg.alpha_out <= s_data.alpha_in;
        end
        if (adv1) begin
            raw2_reg <= raw1_reg;
        end
        if (adv2) begin
            raw3_reg <= raw2_reg;
        end
    end

    assign chan_in[0] = s_data.red_in;
    assign chan_in[1] = s_data.green_in;
    assign chan_in[2] = s_data.blue_in;

    for (genvar k = 0; k < rtc_pkg::NUM_LANES; k++) begin : g_lane
        assign lane_ctl[k].load  = accept;
        assign lane_ctl[k].read  = adv1;
        assign lane_ctl[k].mult  = adv2;
        assign lane_ctl[k].wr_en = adv1 && wr_ok_reg && (sel1_reg == rtc_pkg::LANE_SEL[k]);

        rtc_lane u_lane (
            .aclk    (aclk),
            .ctl     (lane_ctl[k]),
            .chan_in (chan_in[k]),
            .wr_addr (addr1_reg),
            .wr_data (val1_reg),
            .result  (lane_res[k])
        );
    end

    rtc_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (adv3),
        .bypass   (bypass_reg),
        .lane_res (lane_res),
        .raw      (raw3_reg),
        .in_ready (merge_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ===== hdl/rtc_checker.sv =====
// Port-level assertions for the RGB tone curve core, bound to the top level.
module rtc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input rtc_pkg::out_beat_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output beat changed or dropped while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("core not empty after reset");

    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with no output beat pending");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && $past(m_valid && !m_ready))
        else $error("input stalled without an output stall behind it");

endmodule

bind rgb_tone_curve_table_apply_core rtc_checker u_rtc_checker (.*);
